>>> sv/m3cs_pkg.sv
package m3cs_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned LANES  = 4;
	localparam int unsigned ROT_W  = 5;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [LANES-1:0][WORD_W-1:0] quad_t;
	typedef logic [ROT_W-1:0] rot_t;

	typedef struct packed {
		logic vld;
		logic last;
	} ctl_t;

	localparam word_t KEY_CA [LANES] = '{32'h239b961b, 32'hab0e9789, 32'h38b34ae5, 32'ha1e38b93};
	localparam word_t KEY_CB [LANES] = '{32'hab0e9789, 32'h38b34ae5, 32'ha1e38b93, 32'h239b961b};
	localparam rot_t KEY_ROT [LANES] = '{5'd15, 5'd16, 5'd17, 5'd18};
	localparam rot_t LANE_ROT [LANES] = '{5'd19, 5'd17, 5'd15, 5'd13};
	localparam word_t LANE_ADD [LANES] = '{32'h561ccd1b, 32'h0bcaa747, 32'h96cd1c35, 32'h32ac3b17};

	function automatic word_t rotl(input word_t x, input rot_t r);
		logic [ROT_W:0] rr;
		rr = 6'd32 - {1'b0, r};
		return (x << r) | (x >> rr);
	endfunction

	function automatic word_t mul32(input word_t a, input word_t b);
		logic [2*WORD_W-1:0] p;
		p = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
		return p[WORD_W-1:0];
	endfunction

endpackage

>>> sv/m3cs_key_mix.sv
module m3cs_key_mix (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  m3cs_pkg::ctl_t  ctl_in,
	input  m3cs_pkg::quad_t words,
	input  m3cs_pkg::quad_t expect_in,
	output m3cs_pkg::ctl_t  ctl_out,
	output m3cs_pkg::quad_t keys,
	output m3cs_pkg::quad_t expect_out
);
	import m3cs_pkg::*;

	ctl_t  ctl_s1, ctl_s2;
	quad_t prod_s1, keys_s2;
	quad_t expect_s1, expect_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			expect_s1 <= expect_in;
			expect_s2 <= expect_s1;
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		always_ff @(posedge clk) begin
			if (en) begin
				prod_s1[i] <= mul32(words[i], KEY_CA[i]);
				keys_s2[i] <= mul32(rotl(prod_s1[i], KEY_ROT[i]), KEY_CB[i]);
			end
		end
	end

	assign ctl_out    = ctl_s2;
	assign keys       = keys_s2;
	assign expect_out = expect_s2;

endmodule

>>> sv/m3cs_lane_update.sv
module m3cs_lane_update (
	input  logic            clk,
	input  logic            arst_n,
	input  m3cs_pkg::ctl_t  ctl,
	input  m3cs_pkg::quad_t keys,
	input  m3cs_pkg::quad_t expect_in,
	input  logic            res_ready,
	output logic            adv,
	output logic            res_valid,
	output m3cs_pkg::quad_t hash,
	output logic            match
);
	import m3cs_pkg::*;

	quad_t lanes_q;
	quad_t lanes_nx;
	quad_t hash_q;
	logic  match_q;
	logic  out_vld_q;
	logic  take;
	logic  [LANES-1:0] eq;

	// Lanes one to three add the old neighbor; lane four adds the new lane one.
	always_comb begin
		word_t x;
		word_t y;
		word_t n0;
		quad_t nbr;
		n0  = '0;
		nbr = {{WORD_W{1'b0}}, lanes_q[LANES-1:1]};
		for (int i = 0; i < LANES; i++) begin
			x = rotl(lanes_q[i] ^ keys[i], LANE_ROT[i]);
			if (i == LANES - 1) begin
				x = x + n0;
			end else begin
				x = x + nbr[i];
			end
			y = x + (x << 2) + LANE_ADD[i];
			lanes_nx[i] = y;
			if (i == 0) begin
				n0 = y;
			end
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_eq
		assign eq[i] = (lanes_nx[i] == expect_in[i]);
	end

	assign adv  = !out_vld_q || res_ready;
	assign take = adv && ctl.vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_q   <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (take) begin
				lanes_q <= ctl.last ? '0 : lanes_nx;
			end
			if (adv) begin
				out_vld_q <= ctl.vld && ctl.last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && ctl.last) begin
			hash_q  <= lanes_nx;
			match_q <= &eq;
		end
	end

	assign res_valid = out_vld_q;
	assign hash      = hash_q;
	assign match     = match_q;

endmodule

>>> sv/murmur3_128_block_checksum.sv
// Accepts one 16-byte block per clock unless a waiting result stalls it, and runs the MurmurHash3
// x86_128 block round with seed zero on four 32-bit lanes (no tail and no final mix are applied).
// Each block passes two multiplier stages that mix its four words in parallel, then a lane update
// stage holds the loop-carried state and registers the result when the last block reaches it.
// That result carries the four lanes and a flag that is set when they equal the expected words
// sent with the last block; the lanes then clear to zero for the next message. The whole pipeline
// stalls while a result waits, so the input is ready exactly when the output is empty or taken.
module murmur3_128_block_checksum (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// word_a, word_b, word_c, word_d, expect_a, expect_b, expect_c, expect_d
	input  logic [255:0] s_axis_tdata,
	input  logic         s_axis_tlast,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// hash_a, hash_b, hash_c, hash_d
	output logic [127:0] m_axis_tdata,
	// matches_res
	output logic         m_axis_tuser
);
	import m3cs_pkg::*;

	logic  adv;
	ctl_t  ctl_in, ctl_s2;
	quad_t words, expect_in, keys, expect_s2, hash;

	assign ctl_in.vld  = s_axis_tvalid;
	assign ctl_in.last = s_axis_tlast;
	assign words       = s_axis_tdata[127:0];
	assign expect_in   = s_axis_tdata[255:128];

	m3cs_key_mix u_key_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.ctl_in    (ctl_in),
		.words     (words),
		.expect_in (expect_in),
		.ctl_out   (ctl_s2),
		.keys      (keys),
		.expect_out(expect_s2)
	);

	m3cs_lane_update u_lane_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl_s2),
		.keys      (keys),
		.expect_in (expect_s2),
		.res_ready (m_axis_tready),
		.adv       (adv),
		.res_valid (m_axis_tvalid),
		.hash      (hash),
		.match     (m_axis_tuser)
	);

	assign s_axis_tready = adv;
	assign m_axis_tdata  = hash;

`ifndef SYNTH
	a_res_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(ctl_s2.vld && ctl_s2.last))
		else $error("Result raised without a last request in the update stage.");

	a_stall_backs_up: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("Input ready while a result is stalled.");

	a_res_update: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && ctl_s2.vld && !ctl_s2.last) |=> !$rose(m_axis_tvalid))
		else $error("Result raised for a request that is not last.");
`endif

endmodule
